/* rtl/core/sfv_pkg.sv */
// Shared types, constants and elaboration-time table functions for the superellipse fan block.
`default_nettype none

package sfv_pkg;

    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_RADIUS   = 3'd2;
    localparam logic [2:0] REG_DEGREE   = 3'd3;
    localparam logic [2:0] REG_X_SCALE  = 3'd4;
    localparam logic [2:0] REG_Y_SCALE  = 3'd5;

    localparam int EXP_W  = 26;
    localparam int LG_W   = 24;
    localparam int PW_W   = 31;
    localparam int NTERMS = 12;

    // Stage counts of the power and offset pipelines.
    localparam int POW_LAT  = 4 + 2 * NTERMS;
    localparam int OFFS_LAT = 3;

    localparam longint ONE_Q30         = 64'sd1073741824;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam int CORDIC_STEPS        = 24;

    localparam longint ATAN_TURN [CORDIC_STEPS] = '{
        64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
        64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
        64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
        64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
        64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
        64'sd652,       64'sd326,       64'sd163,       64'sd81
    };

    // floor(v / n) for v below 2^31 equals (v * M) >> S with these pairs, n = 1..12.
    localparam logic [31:0] RECIP_M [NTERMS] = '{
        32'd2147483648, 32'd2147483648, 32'd2863311531, 32'd2147483648,
        32'd3435973837, 32'd2863311531, 32'd2454267027, 32'd2147483648,
        32'd3817748708, 32'd3435973837, 32'd3123612579, 32'd2863311531
    };
    localparam int RECIP_S [NTERMS] = '{
        31, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35
    };

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        radius;
        logic [15:0]        x_scale;
        logic [15:0]        y_scale;
        logic [EXP_W-1:0]   expo;
    } cfg_t;

    typedef struct packed {
        logic is_center;
        logic oor;
        logic neg_x;
        logic neg_y;
    } ctl_t;

    typedef struct packed {
        logic neg;
        logic hold;
        logic clear;
    } offs_ctl_t;

    // CORDIC cos or sin of a quadrant point, Q30 clamped to [0, 1].
    function automatic longint sfv_trig(input longint z0, input int idx, input int last,
                                        input bit want_sin);
        longint x;
        longint y;
        longint z;
        longint nx;
        int k;
        if (idx == 0) begin
            return want_sin ? 64'sd0 : ONE_Q30;
        end
        if (idx >= last) begin
            return want_sin ? ONE_Q30 : 64'sd0;
        end
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = z0;
        for (k = 0; k < CORDIC_STEPS; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - ATAN_TURN[k];
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + ATAN_TURN[k];
            end
            x = nx;
        end
        if (x < 0) x = -x;
        if (y < 0) y = -y;
        if (x > ONE_Q30) x = ONE_Q30;
        if (y > ONE_Q30) y = ONE_Q30;
        return want_sin ? y : x;
    endfunction

    // Squaring log2 of a Q30 value, Q16 result with the fraction truncated.
    function automatic logic signed [LG_W-1:0] sfv_log2(input longint u);
        longint m;
        longint lg;
        int p;
        int b;
        int frac;
        bit found;
        if (u <= 0) begin
            return '0;
        end
        p = 0;
        found = 1'b0;
        frac = 0;
        for (b = 30; b >= 0; b--) begin
            if (!found && u[b]) begin
                p = b;
                found = 1'b1;
            end
        end
        m = u << (30 - p);
        for (b = 15; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= 64'sd2147483648) begin
                m = m >> 1;
                frac = frac | (1 << b);
            end
        end
        lg = longint'(p - 30) * 64'sd65536 + longint'(frac);
        return lg[LG_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sfv_cfg.sv */
// Configuration registers and the iterative divider that derives the exponent 2/n.
`default_nettype none

module sfv_cfg
    import sfv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg,
    output logic                    busy
);

    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic [30:0]        radius_reg;
    logic [14:0]        degree_reg;
    logic [15:0]        x_scale_reg;
    logic [15:0]        y_scale_reg;

    logic               div_busy_reg;
    logic [4:0]         div_cnt_reg;
    logic [14:0]        div_rem_reg;
    logic [14:0]        div_den_reg;
    logic [EXP_W-1:0]   div_quo_reg;

    logic               wr;
    logic [2:0]         idx;
    logic [15:0]        shifted;
    logic               qbit;
    logic [15:0]        rem_next;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    // Long division of 2^25 by the degree, one quotient bit a cycle, top bit first.
    assign shifted  = {div_rem_reg, (div_cnt_reg == 5'd25)};
    assign qbit     = (shifted >= {1'b0, div_den_reg});
    assign rem_next = qbit ? (shifted - {1'b0, div_den_reg}) : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= 31'd65536;
            degree_reg   <= 15'd1024;
            x_scale_reg  <= 16'd4096;
            y_scale_reg  <= 16'd4096;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_rem_reg  <= '0;
            div_den_reg  <= 15'd1024;
            div_quo_reg  <= 26'd32768;
        end
        else
        begin
            if (div_busy_reg && !(wr && (idx == REG_DEGREE)))
            begin
                div_rem_reg <= rem_next[14:0];
                div_quo_reg <= {div_quo_reg[EXP_W-2:0], qbit};
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd0)
                begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (wr)
            begin
                case (idx)
                    REG_CENTER_X: center_x_reg <= pwdata;
                    REG_CENTER_Y: center_y_reg <= pwdata;
                    REG_RADIUS:   radius_reg   <= pwdata[30:0];
                    REG_DEGREE:
                    begin
                        degree_reg   <= pwdata[14:0];
                        div_den_reg  <= (pwdata[14:0] == 15'd0) ? 15'd1 : pwdata[14:0];
                        div_rem_reg  <= '0;
                        div_quo_reg  <= '0;
                        div_cnt_reg  <= 5'd25;
                        div_busy_reg <= 1'b1;
                    end
                    REG_X_SCALE:  x_scale_reg  <= pwdata[15:0];
                    REG_Y_SCALE:  y_scale_reg  <= pwdata[15:0];
                    default:      ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_CENTER_X: prdata = center_x_reg;
            REG_CENTER_Y: prdata = center_y_reg;
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            REG_DEGREE:   prdata = {17'd0, degree_reg};
            REG_X_SCALE:  prdata = {16'd0, x_scale_reg};
            REG_Y_SCALE:  prdata = {16'd0, y_scale_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.radius   = radius_reg;
    assign cfg.x_scale  = x_scale_reg;
    assign cfg.y_scale  = y_scale_reg;
    assign cfg.expo     = div_quo_reg;
    assign busy         = div_busy_reg;

endmodule

`default_nettype wire

/* rtl/core/sfv_pow.sv */
// Pipelined power u^e = exp2(e * log2 u), with the log2 taken from a constant table.
`default_nettype none

module sfv_pow
    import sfv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic signed [LG_W-1:0] lg,
    input  wire logic                   zero,
    input  wire logic [EXP_W-1:0]       expo,
    output logic [PW_W-1:0]             pw
);

    logic signed [50:0] prod_a;
    logic signed [33:0] t_reg;
    logic               zero_a_reg;

    logic [45:0]        prod_b;
    logic [17:0]        ipn;
    logic [29:0]        b_x_reg;
    logic [4:0]         b_k_reg;
    logic               b_kill_reg;

    logic [29:0]        c_v_reg    [NTERMS];
    logic [31:0]        c_sum_reg  [NTERMS];
    logic [29:0]        c_x_reg    [NTERMS];
    logic [4:0]         c_k_reg    [NTERMS];
    logic               c_kill_reg [NTERMS];
    logic [30:0]        d_term_reg [NTERMS];
    logic [31:0]        d_sum_reg  [NTERMS];
    logic [29:0]        d_x_reg    [NTERMS];
    logic [4:0]         d_k_reg    [NTERMS];
    logic               d_kill_reg [NTERMS];

    logic [31:0]        e_total_reg;
    logic [4:0]         e_k_reg;
    logic               e_kill_reg;
    logic [31:0]        shifted;
    logic [PW_W-1:0]    pw_reg;

    assign prod_a = lg * $signed({1'b0, expo});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg      <= prod_a[49:16];
            zero_a_reg <= zero;
        end
    end

    // Split t into an integer shift and a fraction that feeds the series as x = f * ln2.
    assign prod_b = 46'(t_reg[15:0]) * 46'(LN2_Q30);
    assign ipn    = ~t_reg[33:16] + 18'd1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_x_reg    <= prod_b[45:16];
            b_k_reg    <= ipn[4:0];
            b_kill_reg <= zero_a_reg || (t_reg < -34'sd2031616);
        end
    end

    for (genvar n = 0; n < NTERMS; n++) begin : g_term
        localparam int SH = RECIP_S[n];
        logic [30:0] prev_term;
        logic [31:0] prev_sum;
        logic [29:0] prev_x;
        logic [4:0]  prev_k;
        logic        prev_kill;
        logic [60:0] pc;
        logic [61:0] pd;

        if (n == 0) begin : g_first
            assign prev_term = 31'(ONE_Q30);
            assign prev_sum  = 32'(ONE_Q30);
            assign prev_x    = b_x_reg;
            assign prev_k    = b_k_reg;
            assign prev_kill = b_kill_reg;
        end else begin : g_next
            assign prev_term = d_term_reg[n-1];
            assign prev_sum  = d_sum_reg[n-1] + 32'(d_term_reg[n-1]);
            assign prev_x    = d_x_reg[n-1];
            assign prev_k    = d_k_reg[n-1];
            assign prev_kill = d_kill_reg[n-1];
        end

        assign pc = 61'(prev_term) * 61'(prev_x);
        assign pd = 62'(c_v_reg[n]) * 62'(RECIP_M[n]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_v_reg[n]    <= pc[59:30];
                c_sum_reg[n]  <= prev_sum;
                c_x_reg[n]    <= prev_x;
                c_k_reg[n]    <= prev_k;
                c_kill_reg[n] <= prev_kill;
                d_term_reg[n] <= 31'(pd >> SH);
                d_sum_reg[n]  <= c_sum_reg[n];
                d_x_reg[n]    <= c_x_reg[n];
                d_k_reg[n]    <= c_k_reg[n];
                d_kill_reg[n] <= c_kill_reg[n];
            end
        end
    end

    assign shifted = e_total_reg >> e_k_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_total_reg <= d_sum_reg[NTERMS-1] + 32'(d_term_reg[NTERMS-1]);
            e_k_reg     <= d_k_reg[NTERMS-1];
            e_kill_reg  <= d_kill_reg[NTERMS-1];
            if (e_kill_reg)
            begin
                pw_reg <= '0;
            end
            else if (shifted > 32'(ONE_Q30))
            begin
                pw_reg <= PW_W'(ONE_Q30);
            end
            else
            begin
                pw_reg <= shifted[PW_W-1:0];
            end
        end
    end

    assign pw = pw_reg;

endmodule

`default_nettype wire

/* rtl/core/sfv_offs.sv */
// Scales a power by axis factor and radius, adds the center and saturates.
`default_nettype none

module sfv_offs
    import sfv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [PW_W-1:0]    pw,
    input  wire logic [15:0]        scale,
    input  wire logic [30:0]        radius,
    input  wire logic signed [31:0] center,
    input  wire offs_ctl_t          ctl,
    output logic signed [31:0]      pos
);

    logic [46:0]        prod1;
    logic [20:0]        factor_reg;
    logic [51:0]        prod2;
    logic [35:0]        off_reg;
    logic signed [37:0] ext_center;
    logic signed [37:0] ext_off;
    logic signed [37:0] sum;
    logic signed [31:0] pos_reg;

    assign prod1 = 47'(scale) * 47'(pw);
    assign prod2 = 52'(factor_reg) * 52'(radius);

    assign ext_center = 38'(center);
    assign ext_off    = $signed({2'b00, off_reg});
    assign sum        = ctl.neg ? (ext_center - ext_off) : (ext_center + ext_off);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            factor_reg <= prod1[46:26];
            off_reg    <= prod2[51:16];
            if (ctl.clear)
            begin
                pos_reg <= '0;
            end
            else if (ctl.hold)
            begin
                pos_reg <= center;
            end
            else if (sum > 38'sd2147483647)
            begin
                pos_reg <= 32'sh7FFFFFFF;
            end
            else if (sum < -38'sd2147483648)
            begin
                pos_reg <= 32'sh80000000;
            end
            else
            begin
                pos_reg <= sum[31:0];
            end
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

/* rtl/core/superellipse_fan_vertex_top.sv */
// Top level of the superellipse triangle-fan vertex generator.
`default_nettype none

// Returns one fan vertex in Q16.16 for each vertex number word: 0 is the center,
// 1..4*POINTS_PER_QUADRANT walk the rim, larger numbers give zero with out_of_range set.
// The pipeline takes one word every cycle unless stalled; a word passes 33 register
// stages before its result is presented. The depth is set by the twelve-term exp2
// series, two multiplier stages per term. While the output word is stalled the whole
// pipeline holds. After a write to the degree register the input is stalled while the
// exponent 2/n is divided out.
// Cos, sin and their log2 come from constant tables built at elaboration.

module superellipse_fan_vertex_top
    import sfv_pkg::*;
#(
    parameter int POINTS_PER_QUADRANT = 41
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               vertex_valid,
    output logic                    vertex_stall,
    input  wire logic [7:0]         vertex_number,
    output logic                    pos_valid,
    input  wire logic               pos_stall,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic                    out_of_range
);

    localparam int PT_W = $clog2(POINTS_PER_QUADRANT);
    localparam int LAT  = 2 + POW_LAT + OFFS_LAT;
    localparam logic [9:0] P1 = 10'(POINTS_PER_QUADRANT);
    localparam logic [9:0] P2 = 10'(2 * POINTS_PER_QUADRANT);
    localparam logic [9:0] P3 = 10'(3 * POINTS_PER_QUADRANT);
    localparam logic [9:0] P4 = 10'(4 * POINTS_PER_QUADRANT);

    cfg_t              cfg;
    logic              busy;
    logic              adv;
    logic              accept;

    logic [LAT-1:0]    valid_reg;
    ctl_t              ctl_reg [LAT];
    ctl_t              ctl_next;

    logic [9:0]        vm1;
    logic [1:0]        quad;
    logic [9:0]        jw;
    logic [9:0]        ptw;
    logic [PT_W-1:0]   pt_reg;

    logic signed [LG_W-1:0] lgc_tab [POINTS_PER_QUADRANT];
    logic signed [LG_W-1:0] lgs_tab [POINTS_PER_QUADRANT];
    logic                   zc_tab  [POINTS_PER_QUADRANT];
    logic                   zs_tab  [POINTS_PER_QUADRANT];

    logic signed [LG_W-1:0] lgc_reg;
    logic signed [LG_W-1:0] lgs_reg;
    logic                   zc_reg;
    logic                   zs_reg;

    logic [PW_W-1:0]   pw_x;
    logic [PW_W-1:0]   pw_y;
    offs_ctl_t         octl_x;
    offs_ctl_t         octl_y;

    sfv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .busy    (busy)
    );

    assign adv          = !(valid_reg[LAT-1] && pos_stall);
    assign vertex_stall = !adv || busy;
    assign accept       = vertex_valid && !vertex_stall;

    // Quadrant and point within it, by comparing against multiples of the quadrant size.
    assign vm1 = 10'(vertex_number) - 10'd1;

    always_comb
    begin
        if (vm1 >= P3)
        begin
            quad = 2'd3;
            jw   = vm1 - P3;
        end
        else if (vm1 >= P2)
        begin
            quad = 2'd2;
            jw   = vm1 - P2;
        end
        else if (vm1 >= P1)
        begin
            quad = 2'd1;
            jw   = vm1 - P1;
        end
        else
        begin
            quad = 2'd0;
            jw   = vm1;
        end
        ptw = quad[0] ? (P1 - 10'd1 - jw) : jw;
        ctl_next.is_center = (vertex_number == 8'd0);
        ctl_next.oor       = (10'(vertex_number) > P4);
        ctl_next.neg_x     = (quad == 2'd1) || (quad == 2'd2);
        ctl_next.neg_y     = quad[1];
    end

    for (genvar gi = 0; gi < POINTS_PER_QUADRANT; gi++) begin : g_tab
        localparam longint ZA   = (longint'(gi) <<< 30) / longint'(POINTS_PER_QUADRANT - 1);
        localparam longint COSV = sfv_trig(ZA, gi, POINTS_PER_QUADRANT - 1, 1'b0);
        localparam longint SINV = sfv_trig(ZA, gi, POINTS_PER_QUADRANT - 1, 1'b1);
        assign lgc_tab[gi] = sfv_log2(COSV);
        assign lgs_tab[gi] = sfv_log2(SINV);
        assign zc_tab[gi]  = (COSV == 64'sd0);
        assign zs_tab[gi]  = (SINV == 64'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl_next;
            for (int s = 1; s < LAT; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            pt_reg  <= ptw[PT_W-1:0];
            lgc_reg <= lgc_tab[pt_reg];
            lgs_reg <= lgs_tab[pt_reg];
            zc_reg  <= zc_tab[pt_reg];
            zs_reg  <= zs_tab[pt_reg];
        end
    end

    sfv_pow u_pow_x (
        .clk  (clk),
        .en   (adv),
        .lg   (lgc_reg),
        .zero (zc_reg),
        .expo (cfg.expo),
        .pw   (pw_x)
    );

    sfv_pow u_pow_y (
        .clk  (clk),
        .en   (adv),
        .lg   (lgs_reg),
        .zero (zs_reg),
        .expo (cfg.expo),
        .pw   (pw_y)
    );

    // Control seen by the final offset stage.
    assign octl_x.neg   = ctl_reg[LAT-2].neg_x;
    assign octl_x.hold  = ctl_reg[LAT-2].is_center;
    assign octl_x.clear = ctl_reg[LAT-2].oor;
    assign octl_y.neg   = ctl_reg[LAT-2].neg_y;
    assign octl_y.hold  = ctl_reg[LAT-2].is_center;
    assign octl_y.clear = ctl_reg[LAT-2].oor;

    sfv_offs u_offs_x (
        .clk    (clk),
        .en     (adv),
        .pw     (pw_x),
        .scale  (cfg.x_scale),
        .radius (cfg.radius),
        .center (cfg.center_x),
        .ctl    (octl_x),
        .pos    (pos_x)
    );

    sfv_offs u_offs_y (
        .clk    (clk),
        .en     (adv),
        .pw     (pw_y),
        .scale  (cfg.y_scale),
        .radius (cfg.radius),
        .center (cfg.center_y),
        .ctl    (octl_y),
        .pos    (pos_y)
    );

    assign pos_valid    = valid_reg[LAT-1];
    assign out_of_range = ctl_reg[LAT-1].oor;

endmodule

`default_nettype wire
